>>> design/fb3d_pkg.sv
`default_nettype none
package fb3d_pkg;

    // fixed field widths of the item and result beats and of the side setting
    localparam int COORD_W = 4;
    localparam int DATA_W  = 32;
    localparam int GRID_W  = 5;

    localparam logic [GRID_W-1:0] GRID_RESET = 5'd16;

    // walk index width: side in use never exceeds 31, so i | (i + 1) stays below 64
    localparam int WALK_W = 6;

    // inclusion-exclusion terms of a box query
    localparam int NUM_TERMS = 8;
    localparam int TERM_W    = 3;
    localparam logic [TERM_W-1:0] TERM_LAST = TERM_W'(NUM_TERMS - 1);

    // operation codes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // one axis step of a tree walk
    typedef struct packed {
        logic [WALK_W-1:0] next;
        logic              wrap;
    } fb3d_step_t;

endpackage
`default_nettype wire

>>> design/fb3d_if.sv
`default_nettype none
interface fb3d_req_if
    import fb3d_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic [COORD_W-1:0]       pos_x;
    logic [COORD_W-1:0]       pos_y;
    logic [COORD_W-1:0]       pos_z;
    logic [COORD_W-1:0]       end_x;
    logic [COORD_W-1:0]       end_y;
    logic [COORD_W-1:0]       end_z;
    logic signed [DATA_W-1:0] add_value;

    modport source (
        output valid, operation, pos_x, pos_y, pos_z, end_x, end_y, end_z, add_value,
        input  ready
    );
    modport sink (
        input  valid, operation, pos_x, pos_y, pos_z, end_x, end_y, end_z, add_value,
        output ready
    );
endinterface

interface fb3d_res_if
    import fb3d_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] box_sum;

    modport source (
        output valid, box_sum,
        input  ready
    );
    modport sink (
        input  valid, box_sum,
        output ready
    );
endinterface
`default_nettype wire

>>> design/fb3d_axis_step.sv
`default_nettype none
module fb3d_axis_step
    import fb3d_pkg::*;
(
    input  wire                query,
    input  wire [WALK_W-1:0]   cur,
    input  wire [WALK_W-1:0]   start,
    input  wire [GRID_W-1:0]   side,
    output fb3d_step_t         step
);

    logic [WALK_W-1:0] inc;
    logic [WALK_W-1:0] up_next;
    logic [WALK_W-1:0] down_mask;
    logic [WALK_W-1:0] raw_next;
    logic              wrap;

    always_comb
    begin
        inc       = cur + 1'b1;
        up_next   = cur | inc;
        down_mask = cur & inc;
        if (query == OP_QUERY)
        begin
            // prefix walk: i -> (i & (i + 1)) - 1, ends below zero
            wrap     = (down_mask == '0);
            raw_next = down_mask - 1'b1;
        end
        else
        begin
            // update walk: i -> i | (i + 1), ends at the side in use
            wrap     = (up_next >= WALK_W'(side));
            raw_next = up_next;
        end
        step.wrap = wrap;
        step.next = wrap ? start : raw_next;
    end

endmodule
`default_nettype wire

>>> design/fenwick_3d_box_sum.sv
`default_nettype none
// update: accept, then per touched cell a read and an add with write back,
//   at most 5*5*5 cells at side 16; a point outside the cube touches no cell
// query: a setup state per inclusion-exclusion term plus one cell read per cycle, then drain
//   and output, at most 8*4*4*4 cell reads at side 16; the single memory read port sets the pace
// one item at a time: req.ready is high only between items
// reset: async active low; then a clearing pass over all SIDE^3 entries zeroes the tree
module fenwick_3d_box_sum
    import fb3d_pkg::*;
#(
    parameter int SIDE       = 16,
    parameter int VALUE_BITS = 32
)(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_we,
    input  wire [GRID_W-1:0]   cfg_data,
    fb3d_req_if.sink           req,
    fb3d_res_if.source         res
);

    localparam int DEPTH = SIDE * SIDE * SIDE;
    localparam int ADW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // sequencer states, one-hot
    typedef enum logic [7:0] {
        ST_CLEAR   = 8'b0000_0001,
        ST_IDLE    = 8'b0000_0010,
        ST_UPD_RD  = 8'b0000_0100,
        ST_UPD_WR  = 8'b0000_1000,
        ST_Q_SETUP = 8'b0001_0000,
        ST_Q_WALK  = 8'b0010_0000,
        ST_Q_DRAIN = 8'b0100_0000,
        ST_Q_OUT   = 8'b1000_0000
    } state_t;

    function automatic logic [WALK_W-1:0] clamp_idx(
        input logic [WALK_W-1:0] v,
        input logic [WALK_W-1:0] lim
    );
        return (v > lim) ? lim : v;
    endfunction

    // control state
    state_t             state_reg,     state_next;
    logic [ADW-1:0]     clr_addr_reg,  clr_addr_next;
    logic [GRID_W-1:0]  grid_size_reg, grid_size_next;
    logic [TERM_W-1:0]  term_reg,      term_next;
    logic               acc_en_reg,    acc_en_next;
    logic               out_valid_reg, out_valid_next;

    // payload state
    logic [COORD_W-1:0]    pos_reg   [3];
    logic [COORD_W-1:0]    end_reg   [3];
    logic [WALK_W-1:0]     idx_reg   [3];
    logic [WALK_W-1:0]     idx_next  [3];
    logic [WALK_W-1:0]     start_reg [3];
    logic [WALK_W-1:0]     start_next[3];
    logic [VALUE_BITS-1:0] val_reg;
    logic [VALUE_BITS-1:0] acc_reg,   acc_next;
    logic                  acc_neg_reg;
    logic [DATA_W-1:0]     out_data_reg;
    logic                  load_out;
    logic [VALUE_BITS-1:0] rd_data_reg;

    // tree storage, one read and one write port
    logic [VALUE_BITS-1:0] mem [DEPTH];
    logic                  mem_we;
    logic [ADW-1:0]        mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic [ADW-1:0]        cur_addr;

    logic [GRID_W-1:0]  side_use;
    logic [WALK_W-1:0]  side_m1;
    logic               side_zero;
    logic [COORD_W-1:0] pos_in [3];
    logic               req_fire;
    logic               upd_ok;

    // per axis prefix corners of the query
    logic [WALK_W-1:0] hi_idx   [3];
    logic [WALK_W-1:0] lo_idx   [3];
    logic              lo_empty [3];
    logic [WALK_W-1:0] term_start[3];
    logic              term_empty[3];
    logic              any_empty;

    // walk stepping, z innermost
    fb3d_step_t        step [3];
    logic              walk_query;
    logic              walk_done;
    logic [WALK_W-1:0] idx_adv [3];

    // the shared add/subtract unit
    logic [VALUE_BITS-1:0] opa;
    logic [VALUE_BITS-1:0] opb;
    logic                  sub;
    logic [VALUE_BITS-1:0] sum;

    assign pos_in[0] = req.pos_x;
    assign pos_in[1] = req.pos_y;
    assign pos_in[2] = req.pos_z;

    assign req.ready   = (state_reg == ST_IDLE);
    assign req_fire    = req.valid && req.ready;
    assign res.valid   = out_valid_reg;
    assign res.box_sum = out_data_reg;

    // side in use saturates at the built cube size
    assign side_use  = (32'(grid_size_reg) > SIDE) ? GRID_W'(SIDE) : grid_size_reg;
    assign side_zero = (side_use == '0);
    assign side_m1   = WALK_W'(side_use) - 1'b1;

    assign upd_ok = (WALK_W'(req.pos_x) < WALK_W'(side_use))
                 && (WALK_W'(req.pos_y) < WALK_W'(side_use))
                 && (WALK_W'(req.pos_z) < WALK_W'(side_use));

    assign walk_query = (state_reg == ST_Q_WALK);

    generate
        for (genvar a = 0; a < 3; a++)
        begin : g_axis
            // high corner clamps to side - 1; low prefix ends one below the low corner
            assign hi_idx[a]   = clamp_idx(WALK_W'(end_reg[a]), side_m1);
            assign lo_idx[a]   = clamp_idx(WALK_W'(pos_reg[a]) - 1'b1, side_m1);
            assign lo_empty[a] = side_zero || (pos_reg[a] == '0);

            // term bit 2 picks the low prefix on x, bit 1 on y, bit 0 on z
            assign term_start[a] = term_reg[2 - a] ? lo_idx[a] : hi_idx[a];
            assign term_empty[a] = term_reg[2 - a] ? lo_empty[a] : side_zero;

            fb3d_axis_step u_step (
                .query (walk_query),
                .cur   (idx_reg[a]),
                .start (start_reg[a]),
                .side  (side_use),
                .step  (step[a])
            );
        end
    endgenerate

    assign any_empty = term_empty[0] || term_empty[1] || term_empty[2];

    // odometer advance over the three walks
    assign idx_adv[2] = step[2].next;
    assign idx_adv[1] = step[2].wrap ? step[1].next : idx_reg[1];
    assign idx_adv[0] = (step[2].wrap && step[1].wrap) ? step[0].next : idx_reg[0];
    assign walk_done  = step[0].wrap && step[1].wrap && step[2].wrap;

    assign cur_addr = ADW'(idx_reg[0]) * ADW'(SIDE * SIDE)
                    + ADW'(idx_reg[1]) * ADW'(SIDE)
                    + ADW'(idx_reg[2]);

    // adder: read-modify-write on update, signed accumulate on query
    always_comb
    begin
        if (state_reg == ST_UPD_WR)
        begin
            opa = rd_data_reg;
            opb = val_reg;
            sub = 1'b0;
        end
        else
        begin
            opa = acc_reg;
            opb = rd_data_reg;
            sub = acc_neg_reg;
        end
        sum = opa + (sub ? ~opb : opb) + VALUE_BITS'(sub);
    end

    assign mem_we    = (state_reg == ST_CLEAR) || (state_reg == ST_UPD_WR);
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : cur_addr;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : sum;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        grid_size_next = cfg_we ? cfg_data : grid_size_reg;
        term_next      = term_reg;
        acc_en_next    = (state_reg == ST_Q_WALK);
        out_valid_next = out_valid_reg && !res.ready;
        load_out       = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            idx_next[a]   = idx_reg[a];
            start_next[a] = start_reg[a];
        end
        if (acc_en_reg)
        begin
            acc_next = sum;
        end
        else
        begin
            acc_next = acc_reg;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    acc_next = '0;
                    for (int a = 0; a < 3; a++)
                    begin
                        idx_next[a]   = WALK_W'(pos_in[a]);
                        start_next[a] = WALK_W'(pos_in[a]);
                    end
                    if (req.operation == OP_QUERY)
                    begin
                        term_next  = '0;
                        state_next = ST_Q_SETUP;
                    end
                    else if (upd_ok)
                    begin
                        state_next = ST_UPD_RD;
                    end
                end
            end
            ST_UPD_RD:
            begin
                state_next = ST_UPD_WR;
            end
            ST_UPD_WR:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    idx_next[a] = idx_adv[a];
                end
                state_next = walk_done ? ST_IDLE : ST_UPD_RD;
            end
            ST_Q_SETUP:
            begin
                if (any_empty)
                begin
                    // an empty prefix adds nothing
                    if (term_reg == TERM_LAST)
                    begin
                        state_next = ST_Q_DRAIN;
                    end
                    else
                    begin
                        term_next = term_reg + 1'b1;
                    end
                end
                else
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        idx_next[a]   = term_start[a];
                        start_next[a] = term_start[a];
                    end
                    state_next = ST_Q_WALK;
                end
            end
            ST_Q_WALK:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    idx_next[a] = idx_adv[a];
                end
                if (walk_done)
                begin
                    if (term_reg == TERM_LAST)
                    begin
                        state_next = ST_Q_DRAIN;
                    end
                    else
                    begin
                        term_next  = term_reg + 1'b1;
                        state_next = ST_Q_SETUP;
                    end
                end
            end
            ST_Q_DRAIN:
            begin
                // last read lands in the accumulator here
                state_next = ST_Q_OUT;
            end
            ST_Q_OUT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            grid_size_reg <= GRID_RESET;
            term_reg      <= '0;
            acc_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            grid_size_reg <= grid_size_next;
            term_reg      <= term_next;
            acc_en_reg    <= acc_en_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            pos_reg[0] <= req.pos_x;
            pos_reg[1] <= req.pos_y;
            pos_reg[2] <= req.pos_z;
            end_reg[0] <= req.end_x;
            end_reg[1] <= req.end_y;
            end_reg[2] <= req.end_z;
            val_reg    <= VALUE_BITS'(req.add_value);
        end
        for (int a = 0; a < 3; a++)
        begin
            idx_reg[a]   <= idx_next[a];
            start_reg[a] <= start_next[a];
        end
        acc_reg     <= acc_next;
        // sign of the term whose read is in flight
        acc_neg_reg <= ^term_reg;
        if (load_out)
        begin
            out_data_reg <= DATA_W'(acc_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[cur_addr];
    end

    // walks only ever touch cells inside the cube in use
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_UPD_RD) || (state_reg == ST_UPD_WR) || (state_reg == ST_Q_WALK))
        |-> ((idx_reg[0] < WALK_W'(side_use)) && (idx_reg[1] < WALK_W'(side_use))
            && (idx_reg[2] < WALK_W'(side_use))))
        else $error("tree walk left the cube");

    // clearing pass covers every entry before the first item
    a_clear_full: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(state_reg == ST_CLEAR) |-> ($past(clr_addr_reg) == ADW'(DEPTH - 1)))
        else $error("clearing pass ended early");

    // a result beat only appears at the end of a query
    a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> $past(state_reg == ST_Q_OUT))
        else $error("result beat without a finished query");

    // accumulation never overlaps a tree write
    a_acc_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        acc_en_reg |-> !mem_we)
        else $error("accumulate during tree write");

endmodule
`default_nettype wire

>>> test/fenwick_3d_box_sum_tb.sv
`timescale 1ns / 100ps

module fenwick_3d_box_sum_tb;
    import fb3d_pkg::*;

    // cube side the block is built with, and the widest walk the predictor does
    localparam int MAX_SIDE = 16;

    // settle time after the last beat: covers any box query or update still in flight
    localparam int SETTLE_CYCLES = 600;

    // worst run: every item the longest query, with the longest result stall and send gap,
    // plus the clearing pass; limit is several times that
    localparam int CYCLE_LIMIT = 4_000_000;

    localparam int RANDOM_PER_PHASE = 144;
    localparam int NUM_PHASES       = 8;

    typedef struct {
        logic                     operation;
        logic [COORD_W-1:0]       pos_x;
        logic [COORD_W-1:0]       pos_y;
        logic [COORD_W-1:0]       pos_z;
        logic [COORD_W-1:0]       end_x;
        logic [COORD_W-1:0]       end_y;
        logic [COORD_W-1:0]       end_z;
        logic signed [DATA_W-1:0] add_value;
    } box_item_t;

    typedef struct {
        logic signed [DATA_W-1:0] sum;
        int                       query_no;
    } box_expect_t;

    // how the result side behaves for a while
    typedef enum logic [1:0] {
        DRAIN_FREE,
        DRAIN_COIN,
        DRAIN_HOLD
    } drain_mode_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [GRID_W-1:0] cfg_data;

    fb3d_req_if req_bus ();
    fb3d_res_if res_bus ();

    fenwick_3d_box_sum #(
        .SIDE       (MAX_SIDE),
        .VALUE_BITS (DATA_W)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req_bus),
        .res      (res_bus)
    );

    // predictor state: our own copy of the tree and of the side register
    logic [DATA_W-1:0] tree_model [0:MAX_SIDE-1][0:MAX_SIDE-1][0:MAX_SIDE-1];
    logic [GRID_W-1:0] grid_model;

    box_item_t   queued_items [$];
    box_expect_t pending_sums [$];

    // driver and monitor bookkeeping
    box_item_t   next_item;
    box_item_t   seen_item;
    box_expect_t front_sum;
    logic        req_taken;
    int          burst_left;
    int          gap_left;
    drain_mode_t drain_mode;
    int          drain_left;
    int          hold_left;

    int cycle_count;
    int error_count;
    int n_updates;
    int n_queries;
    int n_results;
    int n_settings;
    int phase_grid [NUM_PHASES];

    // ---------------------------------------------------------------
    // clock
    // ---------------------------------------------------------------
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // side actually walked: the register saturates at the built size
    function automatic int side_used();
        return (grid_model > MAX_SIDE) ? MAX_SIDE : int'(grid_model);
    endfunction

    function automatic int clamp_axis(int v, int n);
        return (v > n - 1) ? n - 1 : v;
    endfunction

    // point update: walk i -> i | (i + 1) on every axis, stay inside the side in use
    function automatic void apply_add(box_item_t it);
        int n;
        int i;
        int j;
        int k;
        n = side_used();
        for (i = int'(it.pos_x); i < n; i = i | (i + 1))
            for (j = int'(it.pos_y); j < n; j = j | (j + 1))
                for (k = int'(it.pos_z); k < n; k = k | (k + 1))
                    tree_model[i][j][k] = tree_model[i][j][k] + it.add_value;
    endfunction

    // prefix sum over [0..cx][0..cy][0..cz]; a negative corner gives an empty sum
    function automatic logic [DATA_W-1:0] corner_sum(int cx, int cy, int cz);
        logic [DATA_W-1:0] acc;
        int i;
        int j;
        int k;
        acc = '0;
        for (i = cx; i >= 0; i = (i & (i + 1)) - 1)
            for (j = cy; j >= 0; j = (j & (j + 1)) - 1)
                for (k = cz; k >= 0; k = (k & (k + 1)) - 1)
                    acc = acc + tree_model[i][j][k];
        return acc;
    endfunction

    // box sum by eight-term inclusion-exclusion, corners clamped, no reordering
    function automatic logic [DATA_W-1:0] box_sum_of(box_item_t it);
        int n;
        int hx;
        int hy;
        int hz;
        int lx;
        int ly;
        int lz;
        logic [DATA_W-1:0] s;
        n  = side_used();
        hx = clamp_axis(int'(it.end_x), n);
        hy = clamp_axis(int'(it.end_y), n);
        hz = clamp_axis(int'(it.end_z), n);
        lx = clamp_axis(int'(it.pos_x) - 1, n);
        ly = clamp_axis(int'(it.pos_y) - 1, n);
        lz = clamp_axis(int'(it.pos_z) - 1, n);
        s = corner_sum(hx, hy, hz);
        s = s - corner_sum(hx, hy, lz);
        s = s - corner_sum(hx, ly, hz);
        s = s - corner_sum(lx, hy, hz);
        s = s + corner_sum(hx, ly, lz);
        s = s + corner_sum(lx, hy, lz);
        s = s + corner_sum(lx, ly, hz);
        s = s - corner_sum(lx, ly, lz);
        return s;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    function automatic box_item_t make_item(logic op, int px, int py, int pz,
                                            int ex, int ey, int ez,
                                            logic [DATA_W-1:0] value);
        box_item_t it;
        it.operation = op;
        it.pos_x     = COORD_W'(px);
        it.pos_y     = COORD_W'(py);
        it.pos_z     = COORD_W'(pz);
        it.end_x     = COORD_W'(ex);
        it.end_y     = COORD_W'(ey);
        it.end_z     = COORD_W'(ez);
        it.add_value = value;
        return it;
    endfunction

    // mostly inside the cube in use, so small sides still see real walks
    function automatic logic [COORD_W-1:0] pick_coord(int side);
        if (side > 0 && $urandom_range(0, 9) < 7)
            return COORD_W'($urandom_range(0, side - 1));
        return COORD_W'($urandom_range(0, MAX_SIDE - 1));
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 7) != 0)
            return $urandom;
        case ($urandom_range(0, 4))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0001;
            default: return 32'h0000_0000;
        endcase
    endfunction

    function automatic box_item_t random_item(int side);
        box_item_t it;
        logic [COORD_W-1:0] lo [3];
        logic [COORD_W-1:0] hi [3];
        logic [COORD_W-1:0] swap;
        it.operation = ($urandom_range(0, 1) == 1) ? OP_QUERY : OP_ADD;
        for (int a = 0; a < 3; a++)
        begin
            lo[a] = pick_coord(side);
            hi[a] = pick_coord(side);
        end
        // most query boxes are well formed; the rest keep the random order, so a low corner may lie above the high one
        if (it.operation == OP_QUERY && $urandom_range(0, 3) != 0)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (lo[a] > hi[a])
                begin
                    swap  = lo[a];
                    lo[a] = hi[a];
                    hi[a] = swap;
                end
            end
        end
        it.pos_x     = lo[0];
        it.pos_y     = lo[1];
        it.pos_z     = lo[2];
        it.end_x     = hi[0];
        it.end_y     = hi[1];
        it.end_z     = hi[2];
        it.add_value = pick_value();
        return it;
    endfunction

    task automatic report_mismatch(string msg);
        error_count++;
        // keep the log short when things go badly wrong
        if (error_count <= 200)
            $display("[%0t] ERROR: %s", $time, msg);
    endtask

    // ---------------------------------------------------------------
    // driver: item beats change at the falling edge, bursts and gaps
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            req_bus.valid <= 1'b0;
        else if (!req_bus.valid || req_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                req_bus.valid <= 1'b0;
            end
            else if (queued_items.size() != 0)
            begin
                next_item = queued_items.pop_front();
                req_bus.operation <= next_item.operation;
                req_bus.pos_x     <= next_item.pos_x;
                req_bus.pos_y     <= next_item.pos_y;
                req_bus.pos_z     <= next_item.pos_z;
                req_bus.end_x     <= next_item.end_x;
                req_bus.end_y     <= next_item.end_y;
                req_bus.end_z     <= next_item.end_z;
                req_bus.add_value <= next_item.add_value;
                req_bus.valid     <= 1'b1;
                // end of burst: pick the next burst length and the gap before it
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    if ($urandom_range(0, 3) == 0)
                        gap_left = 0;
                    else if ($urandom_range(0, 15) == 0)
                        gap_left = $urandom_range(50, 300);
                    else
                        gap_left = $urandom_range(1, 20);
                end
            end
            else
                req_bus.valid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // result side: free-running, coin-toss or held stalls, mode changes now and then
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (drain_left == 0)
        begin
            drain_mode = drain_mode_t'($urandom_range(0, 2));
            drain_left = $urandom_range(50, 400);
        end
        drain_left--;
        case (drain_mode)
            DRAIN_FREE:
                res_bus.ready <= 1'b1;
            DRAIN_COIN:
                res_bus.ready <= ($urandom_range(0, 1) == 1);
            default:
            begin
                if (hold_left > 0)
                begin
                    hold_left--;
                    res_bus.ready <= 1'b0;
                end
                else
                begin
                    res_bus.ready <= 1'b1;
                    if ($urandom_range(0, 3) == 0)
                        hold_left = $urandom_range(1, 30);
                end
            end
        endcase
    end

    // ---------------------------------------------------------------
    // monitor: everything sampled at the rising edge
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count++;
        req_taken <= req_bus.valid && req_bus.ready;

        // register write lands on the same edge in the predictor
        if (cfg_we)
            grid_model = cfg_data;

        // result beat: compare with the oldest expected sum
        if (res_bus.valid && res_bus.ready)
        begin
            n_results++;
            if (pending_sums.size() == 0)
                report_mismatch($sformatf("box_sum beat 0x%08h with no query waiting",
                                          res_bus.box_sum));
            else
            begin
                front_sum = pending_sums.pop_front();
                if (res_bus.box_sum !== front_sum.sum)
                    report_mismatch($sformatf("query %0d box_sum 0x%08h, expected 0x%08h",
                                              front_sum.query_no, res_bus.box_sum,
                                              front_sum.sum));
            end
        end

        // item beat: update the tree copy or queue the expected box sum
        if (req_bus.valid && req_bus.ready)
        begin
            seen_item.operation = req_bus.operation;
            seen_item.pos_x     = req_bus.pos_x;
            seen_item.pos_y     = req_bus.pos_y;
            seen_item.pos_z     = req_bus.pos_z;
            seen_item.end_x     = req_bus.end_x;
            seen_item.end_y     = req_bus.end_y;
            seen_item.end_z     = req_bus.end_z;
            seen_item.add_value = req_bus.add_value;
            if (seen_item.operation == OP_QUERY)
            begin
                front_sum.sum      = box_sum_of(seen_item);
                front_sum.query_no = n_queries;
                pending_sums.push_back(front_sum);
                n_queries++;
            end
            else
            begin
                apply_add(seen_item);
                n_updates++;
            end
        end
    end

    // ---------------------------------------------------------------
    // watchdog
    // ---------------------------------------------------------------
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d box sums outstanding",
                 cycle_count, pending_sums.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    // wait until every item is taken and every sum is back, then let the block settle
    task automatic drain_all();
        while (queued_items.size() != 0 || req_bus.valid || pending_sums.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_grid(int value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= GRID_W'(value);
        @(negedge clk);
        cfg_we   <= 1'b0;
        n_settings++;
    endtask

    initial
    begin
        // every input known from time zero
        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_data           = '0;
        req_bus.valid      = 1'b0;
        req_bus.operation  = OP_ADD;
        req_bus.pos_x      = '0;
        req_bus.pos_y      = '0;
        req_bus.pos_z      = '0;
        req_bus.end_x      = '0;
        req_bus.end_y      = '0;
        req_bus.end_z      = '0;
        req_bus.add_value  = '0;
        res_bus.ready      = 1'b0;
        req_taken          = 1'b0;
        burst_left         = 1;
        gap_left           = 0;
        drain_left         = 0;
        hold_left          = 0;
        drain_mode         = DRAIN_FREE;
        cycle_count        = 0;
        error_count        = 0;
        n_updates          = 0;
        n_queries          = 0;
        n_results          = 0;
        n_settings         = 1;
        grid_model         = GRID_RESET;
        for (int i = 0; i < MAX_SIDE; i++)
            for (int j = 0; j < MAX_SIDE; j++)
                for (int k = 0; k < MAX_SIDE; k++)
                    tree_model[i][j][k] = '0;

        // side settings: below, at and above the built size, and zero
        phase_grid = '{1, 31, 0, 7, 16, 3, 11, 16};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part at the reset side of 16, starting from a clear tree
        queued_items.push_back(make_item(OP_QUERY, 0, 0, 0, 15, 15, 15, 0));
        queued_items.push_back(make_item(OP_ADD, 0, 0, 0, 0, 0, 0, 32'h7fff_ffff));
        queued_items.push_back(make_item(OP_ADD, 15, 15, 15, 15, 15, 15, 32'h8000_0000));
        queued_items.push_back(make_item(OP_ADD, 7, 8, 9, 3, 12, 5, 32'hffff_ffff));
        queued_items.push_back(make_item(OP_ADD, 10, 5, 12, 0, 0, 0, 32'h5555_5555));
        // second max value at another point, so a full-box sum wraps
        queued_items.push_back(make_item(OP_ADD, 3, 3, 3, 15, 15, 15, 32'h7fff_ffff));
        queued_items.push_back(make_item(OP_QUERY, 0, 0, 0, 15, 15, 15, 32'hffff_ffff));
        queued_items.push_back(make_item(OP_QUERY, 0, 0, 0, 0, 0, 0, 0));
        queued_items.push_back(make_item(OP_QUERY, 15, 15, 15, 15, 15, 15, 0));
        queued_items.push_back(make_item(OP_QUERY, 1, 1, 1, 15, 15, 15, 0));
        // low corner above high corner on every axis
        queued_items.push_back(make_item(OP_QUERY, 12, 9, 14, 2, 3, 1, 0));
        // low corner zero on x and z only
        queued_items.push_back(make_item(OP_QUERY, 0, 5, 0, 15, 5, 15, 0));
        queued_items.push_back(make_item(OP_QUERY, 7, 8, 9, 7, 8, 9, 0));
        queued_items.push_back(make_item(OP_ADD, 15, 0, 15, 15, 15, 15, 32'h0000_0001));
        queued_items.push_back(make_item(OP_ADD, 0, 15, 0, 15, 15, 15, 32'haaaa_aaaa));
        queued_items.push_back(make_item(OP_QUERY, 0, 0, 0, 15, 0, 15, 0));
        queued_items.push_back(make_item(OP_QUERY, 8, 0, 4, 15, 15, 15, 0));
        queued_items.push_back(make_item(OP_QUERY, 3, 3, 3, 10, 5, 12, 0));
        drain_all();

        // random phases, one side setting each; the tree carries over between them
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_grid(phase_grid[p]);
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                queued_items.push_back(random_item(
                    (phase_grid[p] > MAX_SIDE) ? MAX_SIDE : phase_grid[p]));
            drain_all();
        end

        $display("covered %0d point updates and %0d box queries over %0d side settings",
                 n_updates, n_queries, n_settings);
        $display("%0d box sums checked in %0d cycles, %0d mismatches",
                 n_results, cycle_count, error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
design/fb3d_pkg.sv
design/fb3d_if.sv
design/fb3d_axis_step.sv
design/fenwick_3d_box_sum.sv
test/fenwick_3d_box_sum_tb.sv
